FILE: hw/rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg: shared types and constants of the ray/sphere intersection block
// Stream widths, the work item handed from the front end to the back end,
// queue status, and the magnitude helper used on both sides.
// ----------------------------------------------------------------------------
package rsi_pkg;

	// stream widths (whole bytes), result pad width and queue depth
	localparam int unsigned IN_W       = 224;
	localparam int unsigned OUT_W      = 88;
	localparam int unsigned OUT_PAD_W  = 7;
	localparam int unsigned FIFO_DEPTH = 4;

	// field widths
	localparam int unsigned COORD_W = 32;
	localparam int unsigned RAD_W   = 31;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned NORM_W  = 16;

	// classified ray handed to the back end
	typedef struct packed {
		logic                        live;  // still a candidate hit
		logic [127:0]                q;     // quarter discriminant m^2 - a*c
		logic [63:0]                 m;     // -(S.D)
		logic [63:0]                 c;     // |S|^2 - r^2
		logic [2:0][COORD_W-1:0]     s;     // start, two's complement
		logic [2:0][COORD_W-1:0]     d;     // direction, two's complement
	} ray_work_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	// magnitude of a two's complement word, as unsigned
	function automatic logic [COORD_W-1:0] mag32(input logic [COORD_W-1:0] v);
		return v[COORD_W-1] ? (COORD_W'(0) - v) : v;
	endfunction

endpackage

FILE: hw/rtl/rsi_fifo.sv
// ----------------------------------------------------------------------------
// rsi_fifo: short request queue between front end and back end
// Register array with read and write pointers and a fill count; the head
// entry is presented combinationally.
// ----------------------------------------------------------------------------
module rsi_fifo #(
	parameter int unsigned DEPTH = rsi_pkg::FIFO_DEPTH,
	parameter int unsigned W     = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [W-1:0]        push_data,
	input  logic                pop,
	output logic [W-1:0]        pop_data,
	output rsi_pkg::fifo_stat_t stat
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_q;
	logic [AW-1:0] rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign pop_data   = mem_q[rd_q];

	// store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/rsi_isqrt.sv
// ----------------------------------------------------------------------------
// rsi_isqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(rad)), with a sideband word carried
// alongside. All stages advance together on en.
// ----------------------------------------------------------------------------
module rsi_isqrt #(
	parameter int unsigned NW = 128,
	parameter int unsigned SW = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [NW-1:0]   in_rad,
	input  logic [SW-1:0]   in_side,
	output logic            out_valid,
	output logic [NW/2-1:0] out_root,
	output logic [SW-1:0]   out_side
);

	localparam int unsigned RW = NW / 2;

	logic            vld_s  [RW+1];
	logic [NW-1:0]   rad_s  [RW+1];
	logic [RW+1:0]   rem_s  [RW+1];
	logic [RW-1:0]   root_s [RW+1];
	logic [SW-1:0]   side_s [RW+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = in_rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar i = 1; i <= RW; i++) begin : g_stage
		logic [RW+1:0] cur;
		logic [RW+1:0] trial;
		logic          ge;

		// bring down two radicand bits and try the next root bit
		assign cur   = {rem_s[i-1][RW-1:0], rad_s[i-1][NW-1 -: 2]};
		assign trial = {root_s[i-1], 2'b01};
		assign ge    = (cur >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i]  <= ge ? (cur - trial) : cur;
				root_s[i] <= {root_s[i-1][RW-2:0], ge};
				rad_s[i]  <= rad_s[i-1] << 2;
				side_s[i] <= side_s[i-1];
			end
		end
	end

	assign out_valid = vld_s[RW];
	assign out_root  = root_s[RW];
	assign out_side  = side_s[RW];

endmodule

FILE: hw/rtl/rsi_div.sv
// ----------------------------------------------------------------------------
// rsi_div: pipelined restoring divider
// One quotient bit per stage for LANES numerators over a shared divisor.
// The quotient must fit QW bits (num < den * 2^QW).
// ----------------------------------------------------------------------------
module rsi_div #(
	parameter int unsigned NW    = 80,
	parameter int unsigned DW    = 65,
	parameter int unsigned QW    = 32,
	parameter int unsigned LANES = 1,
	parameter int unsigned SW    = 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  in_valid,
	input  logic [LANES*NW-1:0]   in_num,
	input  logic [DW-1:0]         in_den,
	input  logic [SW-1:0]         in_side,
	output logic                  out_valid,
	output logic [LANES*QW-1:0]   out_quo,
	output logic [SW-1:0]         out_side
);

	localparam int unsigned RW = (NW > DW + QW) ? NW : DW + QW;

	logic          vld_s  [QW+1];
	logic [DW-1:0] den_s  [QW+1];
	logic [RW-1:0] rem_s  [QW+1][LANES];
	logic [QW-1:0] quo_s  [QW+1][LANES];
	logic [SW-1:0] side_s [QW+1];

	assign vld_s[0]  = in_valid;
	assign den_s[0]  = in_den;
	assign side_s[0] = in_side;

	for (genvar l = 0; l < LANES; l++) begin : g_in
		assign rem_s[0][l] = RW'(in_num[l*NW +: NW]);
		assign quo_s[0][l] = '0;
		assign out_quo[l*QW +: QW] = quo_s[QW][l];
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [RW-1:0] dsh;

		// divisor aligned to the quotient bit of this stage
		assign dsh = RW'(den_s[k-1]) << (QW - k);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end

		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic ge;

			assign ge = (rem_s[k-1][l] >= dsh);

			// subtract where it fits and shift in the quotient bit
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? (rem_s[k-1][l] - dsh) : rem_s[k-1][l];
					quo_s[k][l] <= {quo_s[k-1][l][QW-2:0], ge};
				end
			end
		end
	end

	assign out_valid = vld_s[QW];
	assign out_side  = side_s[QW];

endmodule

FILE: hw/rtl/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front: ray classification front end
// Slab rejection, dot products, and the quarter discriminant; each ray
// leaves with a live flag and the terms the back end solves with.
// ----------------------------------------------------------------------------
module rsi_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [rsi_pkg::IN_W-1:0]   in_data,
	input  rsi_pkg::fifo_stat_t        fifo_stat,
	output logic                       item_valid,
	output rsi_pkg::ray_work_t         item
);

	logic                en;
	logic [7:1]          vld_s;

	logic [2:0][31:0]    s_in;
	logic [2:0][31:0]    d_in;
	logic [30:0]         r_in;
	logic                box_in;
	logic [2:0]          slab;

	logic [2:0][31:0]    ms;
	logic [2:0][31:0]    md;
	logic [63:0]         pos_c;
	logic [63:0]         neg_c;

	logic [2:0][31:0]    s_s1, s_s2, s_s3, s_s4, s_s5, s_s6, s_s7;
	logic [2:0][31:0]    d_s1, d_s2, d_s3, d_s4, d_s5, d_s6, d_s7;
	logic [30:0]         r_s1;
	logic                rej_s1, rej_s2, rej_s3;
	logic [2:0][63:0]    sq_s2, dq_s2, sd_s2;
	logic [2:0]          opp_s2;
	logic [61:0]         rr_s2, rr_s3;
	logic [63:0]         ss_s3, aa_s3, pos_s3, neg_s3;
	logic [63:0]         c_s4, m_s4, aa_s4;
	logic                live_s4, live_s5, live_s6, live_s7;
	logic [63:0]         mm00_s5, mm01_s5, mm11_s5;
	logic [63:0]         ac00_s5, ac01_s5, ac10_s5, ac11_s5;
	logic [63:0]         c_s5, m_s5, c_s6, m_s6, c_s7, m_s7;
	logic [127:0]        m2_s6, ac_s6, q_s7;

	// axis lies outside the slab and does not move into it
	function automatic logic slab_out(input logic [31:0] s, input logic [31:0] d,
		input logic [30:0] r);
		logic signed [33:0] sv;
		logic signed [33:0] dv;
		logic signed [33:0] rv;
		logic signed [33:0] sd;
		sv = {{2{s[31]}}, s};
		dv = {{2{d[31]}}, d};
		rv = {3'b000, r};
		sd = sv + dv;
		return ((sv <= -rv) && ((dv <= 0) || (sd < -rv))) ||
			((sv >= rv) && ((dv >= 0) || (sd > rv)));
	endfunction

	// stall only when the last stage holds a ray the queue cannot take
	assign en         = !vld_s[7] || !fifo_stat.full;
	assign in_ready   = en;
	assign item_valid = vld_s[7];

	// unpack the request
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			s_in[i] = in_data[i*32 +: 32];
			d_in[i] = in_data[96 + i*32 +: 32];
			slab[i] = 1'b0;
		end
		r_in   = in_data[222:192];
		box_in = in_data[223];
		for (int i = 0; i < 3; i++) begin
			slab[i] = slab_out(s_in[i], d_in[i], r_in);
		end
	end

	always_comb begin
		pos_c = '0;
		neg_c = '0;
		for (int i = 0; i < 3; i++) begin
			ms[i] = rsi_pkg::mag32(s_s1[i]);
			md[i] = rsi_pkg::mag32(d_s1[i]);
		end
		for (int i = 0; i < 3; i++) begin
			if (opp_s2[i]) begin
				neg_c = neg_c + sd_s2[i];
			end else begin
				pos_c = pos_c + sd_s2[i];
			end
		end
	end

	// advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[6:1], in_valid};
		end
	end

	// stage 1: capture the ray, slab test
	always_ff @(posedge clk) begin
		if (en) begin
			s_s1   <= s_in;
			d_s1   <= d_in;
			r_s1   <= r_in;
			rej_s1 <= box_in && (|slab);
		end
	end

	// stage 2: squares and cross products of magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s2[i]  <= ms[i] * ms[i];
				dq_s2[i]  <= md[i] * md[i];
				sd_s2[i]  <= ms[i] * md[i];
				opp_s2[i] <= s_s1[i][31] ^ d_s1[i][31];
			end
			rr_s2  <= r_s1 * r_s1;
			rej_s2 <= rej_s1;
			s_s2   <= s_s1;
			d_s2   <= d_s1;
		end
	end

	// stage 3: dot products
	always_ff @(posedge clk) begin
		if (en) begin
			ss_s3  <= sq_s2[0] + sq_s2[1] + sq_s2[2];
			aa_s3  <= dq_s2[0] + dq_s2[1] + dq_s2[2];
			pos_s3 <= pos_c;
			neg_s3 <= neg_c;
			rr_s3  <= rr_s2;
			rej_s3 <= rej_s2;
			s_s3   <= s_s2;
			d_s3   <= d_s2;
		end
	end

	// stage 4: drop slab rejects, starts inside, zero direction, and rays moving away
	always_ff @(posedge clk) begin
		if (en) begin
			c_s4    <= ss_s3 - 64'(rr_s3);
			m_s4    <= neg_s3 - pos_s3;
			aa_s4   <= aa_s3;
			live_s4 <= !rej_s3 && (ss_s3 >= 64'(rr_s3)) && (aa_s3 != '0) &&
				(pos_s3 < neg_s3);
			s_s4    <= s_s3;
			d_s4    <= d_s3;
		end
	end

	// stage 5: 32x32 partial products of m*m and a*c
	always_ff @(posedge clk) begin
		if (en) begin
			mm00_s5 <= m_s4[31:0] * m_s4[31:0];
			mm01_s5 <= m_s4[31:0] * m_s4[63:32];
			mm11_s5 <= m_s4[63:32] * m_s4[63:32];
			ac00_s5 <= aa_s4[31:0] * c_s4[31:0];
			ac01_s5 <= aa_s4[31:0] * c_s4[63:32];
			ac10_s5 <= aa_s4[63:32] * c_s4[31:0];
			ac11_s5 <= aa_s4[63:32] * c_s4[63:32];
			c_s5    <= c_s4;
			m_s5    <= m_s4;
			live_s5 <= live_s4;
			s_s5    <= s_s4;
			d_s5    <= d_s4;
		end
	end

	// stage 6: assemble the 128-bit products
	always_ff @(posedge clk) begin
		if (en) begin
			m2_s6   <= {64'd0, mm00_s5} + ({64'd0, mm01_s5} << 33) + {mm11_s5, 64'd0};
			ac_s6   <= {64'd0, ac00_s5} + ({64'd0, ac01_s5} << 32) +
				({64'd0, ac10_s5} << 32) + {ac11_s5, 64'd0};
			c_s6    <= c_s5;
			m_s6    <= m_s5;
			live_s6 <= live_s5;
			s_s6    <= s_s5;
			d_s6    <= d_s5;
		end
	end

	// stage 7: drop a discriminant that is not positive
	always_ff @(posedge clk) begin
		if (en) begin
			q_s7    <= m2_s6 - ac_s6;
			live_s7 <= live_s6 && (ac_s6 < m2_s6);
			c_s7    <= c_s6;
			m_s7    <= m_s6;
			s_s7    <= s_s6;
			d_s7    <= d_s6;
		end
	end

	assign item.live = live_s7;
	assign item.q    = q_s7;
	assign item.m    = m_s7;
	assign item.c    = c_s7;
	assign item.s    = s_s7;
	assign item.d    = d_s7;

endmodule

FILE: hw/rtl/rsi_back.sv
// ----------------------------------------------------------------------------
// rsi_back: intersection solver back end
// Root of the discriminant, entry time division, entry point, its length
// and the normal division; ends in the result register.
// ----------------------------------------------------------------------------
module rsi_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rsi_pkg::fifo_stat_t        fifo_stat,
	input  rsi_pkg::ray_work_t         in_item,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [rsi_pkg::OUT_W-1:0]  out_data
);

	typedef struct packed {
		logic             live;
		logic [63:0]      m;
		logic [63:0]      c;
		logic [2:0][31:0] s;
		logic [2:0][31:0] d;
	} sqrt_side_t;

	typedef struct packed {
		logic             live;
		logic             sat;
		logic [2:0][31:0] s;
		logic [2:0][31:0] d;
	} tdiv_side_t;

	typedef struct packed {
		logic             live;
		logic [31:0]      t;
		logic [2:0][47:0] mp;
		logic [2:0]       pneg;
	} len_side_t;

	typedef struct packed {
		logic             live;
		logic [31:0]      t;
		logic [2:0]       pneg;
		logic             nz;
	} ndiv_side_t;

	logic              en;

	sqrt_side_t        sq1_in_side;
	sqrt_side_t        sq1_side;
	logic              sq1_valid;
	logic [63:0]       sq1_root;
	logic [64:0]       den_c;

	logic              vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [64:0]       den_s1;
	logic [79:0]       num_s1;
	tdiv_side_t        tside_s1;

	logic              dv1_valid;
	logic [31:0]       dv1_quo;
	tdiv_side_t        dv1_side;
	logic [31:0]       t_c;

	logic [2:0][63:0]  prod_s2;
	logic [2:0][31:0]  s_s2;
	logic [2:0]        dneg_s2;
	logic [31:0]       t_s2, t_s3, t_s4, t_s5;
	logic              live_s2, live_s3, live_s4, live_s5;

	logic [2:0][48:0]  p_c;
	logic [2:0][48:0]  pabs_c;
	logic [2:0][47:0]  mp_s3, mp_s4, mp_s5;
	logic [2:0]        pneg_s3, pneg_s4, pneg_s5;
	logic [2:0][47:0]  ll_s4, lh_s4, hh_s4;
	logic [2:0][95:0]  sqv_s5;
	logic [97:0]       psq_s6;
	len_side_t         lside_s6;

	logic              sq2_valid;
	logic [48:0]       sq2_root;
	len_side_t         sq2_side;

	logic [48:0]       len_s7;
	logic [185:0]      num_s7;
	ndiv_side_t        nside_s7;

	logic              dv2_valid;
	logic [44:0]       dv2_quo;
	ndiv_side_t        dv2_side;
	logic [2:0][15:0]  norm_c;

	logic [rsi_pkg::OUT_W-1:0] res_s8;

	// hold the whole pipeline while the result waits
	assign en        = !vld_s8 || out_ready;
	assign pop       = en && !fifo_stat.empty;
	assign out_valid = vld_s8;
	assign out_data  = res_s8;

	assign sq1_in_side.live = in_item.live;
	assign sq1_in_side.m    = in_item.m;
	assign sq1_in_side.c    = in_item.c;
	assign sq1_in_side.s    = in_item.s;
	assign sq1_in_side.d    = in_item.d;

	// root of the quarter discriminant
	rsi_isqrt #(
		.NW (128),
		.SW ($bits(sqrt_side_t))
	) u_sqrt_q (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (!fifo_stat.empty),
		.in_rad    (in_item.q),
		.in_side   (sq1_in_side),
		.out_valid (sq1_valid),
		.out_root  (sq1_root),
		.out_side  (sq1_side)
	);

	assign den_c = {1'b0, sq1_side.m} + {1'b0, sq1_root};

	// stage 1: divisor and saturation check
	always_ff @(posedge clk) begin
		if (en) begin
			den_s1        <= den_c;
			num_s1        <= {sq1_side.c, 16'd0};
			tside_s1.live <= sq1_side.live;
			tside_s1.sat  <= ({17'd0, sq1_side.c} >= {den_c, 16'd0});
			tside_s1.s    <= sq1_side.s;
			tside_s1.d    <= sq1_side.d;
		end
	end

	// entry time c * 2^16 / (m + sqrt(q))
	rsi_div #(
		.NW    (80),
		.DW    (65),
		.QW    (32),
		.LANES (1),
		.SW    ($bits(tdiv_side_t))
	) u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_num    (num_s1),
		.in_den    (den_s1),
		.in_side   (tside_s1),
		.out_valid (dv1_valid),
		.out_quo   (dv1_quo),
		.out_side  (dv1_side)
	);

	assign t_c = dv1_side.sat ? '1 : dv1_quo;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_c[i]    = dneg_s2[i] ?
				({{17{s_s2[i][31]}}, s_s2[i]} - {1'b0, prod_s2[i][63:16]}) :
				({{17{s_s2[i][31]}}, s_s2[i]} + {1'b0, prod_s2[i][63:16]});
			pabs_c[i] = p_c[i][48] ? (49'd0 - p_c[i]) : p_c[i];
		end
	end

	// stage 2: travel along each axis
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[i] <= rsi_pkg::mag32(dv1_side.d[i]) * t_c;
				dneg_s2[i] <= dv1_side.d[i][31];
			end
			s_s2    <= dv1_side.s;
			t_s2    <= t_c;
			live_s2 <= dv1_side.live;
		end
	end

	// stage 3: entry point magnitude and sign
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				mp_s3[i]   <= pabs_c[i][47:0];
				pneg_s3[i] <= p_c[i][48];
			end
			t_s3    <= t_s2;
			live_s3 <= live_s2;
		end
	end

	// stage 4: 24x24 partial products of the squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				ll_s4[i] <= mp_s3[i][23:0] * mp_s3[i][23:0];
				lh_s4[i] <= mp_s3[i][23:0] * mp_s3[i][47:24];
				hh_s4[i] <= mp_s3[i][47:24] * mp_s3[i][47:24];
			end
			mp_s4   <= mp_s3;
			pneg_s4 <= pneg_s3;
			t_s4    <= t_s3;
			live_s4 <= live_s3;
		end
	end

	// stage 5: assemble squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqv_s5[i] <= {48'd0, ll_s4[i]} + ({48'd0, lh_s4[i]} << 25) +
					{hh_s4[i], 48'd0};
			end
			mp_s5   <= mp_s4;
			pneg_s5 <= pneg_s4;
			t_s5    <= t_s4;
			live_s5 <= live_s4;
		end
	end

	// stage 6: squared length of the entry point
	always_ff @(posedge clk) begin
		if (en) begin
			psq_s6        <= 98'(sqv_s5[0]) + 98'(sqv_s5[1]) + 98'(sqv_s5[2]);
			lside_s6.live <= live_s5;
			lside_s6.t    <= t_s5;
			lside_s6.mp   <= mp_s5;
			lside_s6.pneg <= pneg_s5;
		end
	end

	// length of the entry point
	rsi_isqrt #(
		.NW (98),
		.SW ($bits(len_side_t))
	) u_sqrt_len (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s6),
		.in_rad    (psq_s6),
		.in_side   (lside_s6),
		.out_valid (sq2_valid),
		.out_root  (sq2_root),
		.out_side  (sq2_side)
	);

	// stage 7: normal numerators
	always_ff @(posedge clk) begin
		if (en) begin
			len_s7        <= sq2_root;
			num_s7        <= {sq2_side.mp[2], 14'd0, sq2_side.mp[1], 14'd0,
				sq2_side.mp[0], 14'd0};
			nside_s7.live <= sq2_side.live;
			nside_s7.t    <= sq2_side.t;
			nside_s7.pneg <= sq2_side.pneg;
			nside_s7.nz   <= (sq2_root != '0);
		end
	end

	// three normal components over the shared length
	rsi_div #(
		.NW    (62),
		.DW    (49),
		.QW    (15),
		.LANES (3),
		.SW    ($bits(ndiv_side_t))
	) u_div_n (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s7),
		.in_num    (num_s7),
		.in_den    (len_s7),
		.in_side   (nside_s7),
		.out_valid (dv2_valid),
		.out_quo   (dv2_quo),
		.out_side  (dv2_side)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			norm_c[i] = '0;
			if (dv2_side.live && dv2_side.nz) begin
				norm_c[i] = dv2_side.pneg[i] ? (16'd0 - {1'b0, dv2_quo[i*15 +: 15]}) :
					{1'b0, dv2_quo[i*15 +: 15]};
			end
		end
	end

	// stage 8: result register, zero everything on a miss
	always_ff @(posedge clk) begin
		if (en) begin
			res_s8 <= {{rsi_pkg::OUT_PAD_W{1'b0}}, norm_c[2], norm_c[1], norm_c[0],
				(dv2_side.live ? dv2_side.t : 32'd0), dv2_side.live};
		end
	end

	// advance the valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sq1_valid;
			vld_s2 <= dv1_valid;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= sq2_valid;
			vld_s8 <= dv2_valid;
		end
	end

endmodule

FILE: hw/rtl/ray_sphere_intersect.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersect: ray against origin-centered sphere, Q16.16
// Entry time and unit normal of a ray hitting a sphere, one request a cycle while s_tready is high.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_tvalid/s_tready/s_tdata, one ray per beat; results
//   leave on m_tvalid/m_tready/m_tdata, exactly one per request, in order.
//   A miss returns hit = 0 with time and normal all zero.
//   Throughput is one request per cycle while s_tready is high. A result
//   passes through 7 classify stages (the first loads at the accepting edge),
//   the queue write, 64 root stages, the divisor stage, 32 time-divide
//   stages, 5 entry-point stages, 49 length root stages, the numerator stage,
//   15 normal-divide stages and the result register, then m_tvalid rises.
//   When m_tready is low the solver pipeline holds; the classify front keeps
//   taking requests until the queue between the two fills, then s_tready
//   drops. Asynchronous reset empties every pipeline stage and the queue;
//   s_tready is high right after reset.
// ----------------------------------------------------------------------------
module ray_sphere_intersect #(
	parameter int unsigned FIFO_DEPTH = rsi_pkg::FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	// start_x, start_y, start_z, dir_x, dir_y, dir_z, radius, box_reject
	input  logic [rsi_pkg::IN_W-1:0]   s_tdata,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// hit, hit_time, norm_x, norm_y, norm_z, zero pad
	output logic [rsi_pkg::OUT_W-1:0]  m_tdata
);

	rsi_pkg::fifo_stat_t fifo_stat;
	rsi_pkg::ray_work_t  front_item;
	rsi_pkg::ray_work_t  back_item;
	logic                front_valid;
	logic                back_pop;

	rsi_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.fifo_stat  (fifo_stat),
		.item_valid (front_valid),
		.item       (front_item)
	);

	rsi_fifo #(
		.DEPTH (FIFO_DEPTH),
		.W     ($bits(rsi_pkg::ray_work_t))
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_item),
		.pop       (back_pop),
		.pop_data  (back_item),
		.stat      (fifo_stat)
	);

	rsi_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_stat (fifo_stat),
		.in_item   (back_item),
		.pop       (back_pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

`ifndef ASSERT_OFF
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[0]) |-> (m_tdata[80:1] == '0))
		else $error("miss result carries nonzero time or normal");

	a_norm_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |->
		($signed(m_tdata[48:33]) >= -16'sd16384) && ($signed(m_tdata[48:33]) <= 16'sd16384) &&
		($signed(m_tdata[64:49]) >= -16'sd16384) && ($signed(m_tdata[64:49]) <= 16'sd16384) &&
		($signed(m_tdata[80:65]) >= -16'sd16384) && ($signed(m_tdata[80:65]) <= 16'sd16384))
		else $error("normal component outside unit range");

	a_fifo_stat: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_stat.full && fifo_stat.empty))
		else $error("queue reports full and empty");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[87:81] == '0))
		else $error("result pad bits not zero");
`endif

endmodule

FILE: tb/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker: result checker of the ray/sphere intersection block
// Watches both streams, predicts each accepted request's result with exact
// wide arithmetic and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module rsi_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [rsi_pkg::IN_W-1:0]  s_tdata,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [rsi_pkg::OUT_W-1:0] m_tdata,
	output int                        fail_count,
	output int                        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        hit;
		logic [31:0] hit_time;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
	} hit_rec_t;

	hit_rec_t expected_hits[$];
	int       mismatches;

	// integer square root of a 128-bit value, floor
	function automatic logic [127:0] root128(input logic [127:0] n);
		logic [127:0] res, bit_v, trial;
		res = '0;
		bit_v = 128'd1 << 126;
		while (bit_v > n) bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			trial = res + bit_v;
			if (n >= trial) begin
				n = n - trial;
				res = (res >> 1) + bit_v;
			end else begin
				res = res >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return res;
	endfunction

	function automatic logic slab_out(input longint s, input longint d, input longint r);
		if (s <= -r && (d <= 0 || s + d < -r)) return 1'b1;
		if (s >= r && (d >= 0 || s + d > r)) return 1'b1;
		return 1'b0;
	endfunction

	// predict the result of one ray
	function automatic hit_rec_t trace_ray(input logic [rsi_pkg::IN_W-1:0] w);
		hit_rec_t         h;
		longint           s[3], d[3], p[3];
		longint           r;
		logic [63:0]      ms, md, ss, aa, pos, neg, c, m, t, step, len, nrm;
		logic [127:0]     q, den, quo, psq, m2, ac;
		logic [15:0]      nv[3];
		h = '0;
		for (int i = 0; i < 3; i++) begin
			s[i] = longint'(signed'(w[32*i +: 32]));
			d[i] = longint'(signed'(w[96 + 32*i +: 32]));
		end
		r = longint'({33'd0, w[192 +: 31]});
		if (w[223]) begin
			for (int i = 2; i >= 0; i--)
				if (slab_out(s[i], d[i], r)) return h;
		end
		ss = 0; aa = 0; pos = 0; neg = 0;
		for (int i = 0; i < 3; i++) begin
			ms = s[i] < 0 ? -s[i] : s[i];
			md = d[i] < 0 ? -d[i] : d[i];
			ss += ms * ms;
			aa += md * md;
			if ((s[i] < 0) != (d[i] < 0)) neg += ms * md; else pos += ms * md;
		end
		if (ss < r * r) return h;
		c = ss - r * r;
		if (aa == 0 || pos >= neg) return h;
		m = neg - pos;
		m2 = {64'd0, m} * {64'd0, m};
		ac = {64'd0, aa} * {64'd0, c};
		if (ac >= m2) return h;
		q = m2 - ac;
		den = {64'd0, m} + root128(q);
		quo = ({64'd0, c} << 16) / den;
		t = (quo > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : quo[63:0];
		psq = '0;
		for (int i = 0; i < 3; i++) begin
			md = d[i] < 0 ? -d[i] : d[i];
			step = (md * t) >> 16;
			p[i] = d[i] < 0 ? s[i] - longint'(step) : s[i] + longint'(step);
			ms = p[i] < 0 ? -p[i] : p[i];
			psq += {64'd0, ms} * {64'd0, ms};
		end
		len = root128(psq);
		for (int i = 0; i < 3; i++) begin
			nrm = 0;
			if (len != 0) begin
				ms = p[i] < 0 ? -p[i] : p[i];
				nrm = (ms << 14) / len;
				if (p[i] < 0) nrm = -nrm;
			end
			nv[i] = nrm[15:0];
		end
		h.hit = 1'b1;
		h.hit_time = t[31:0];
		h.nx = nv[0]; h.ny = nv[1]; h.nz = nv[2];
		return h;
	endfunction

	assign fail_count = mismatches;
	assign pending = expected_hits.size();

	// predict on requests, compare on results
	always @(posedge clk or negedge arst_n) begin
		hit_rec_t want, got;
		if (!arst_n) begin
			expected_hits.delete();
			mismatches <= 0;
		end else begin
			if (s_tvalid && s_tready) expected_hits.push_back(trace_ray(s_tdata));
			if (m_tvalid && m_tready) begin
				got.hit = m_tdata[0];
				got.hit_time = m_tdata[32:1];
				got.nx = m_tdata[48:33];
				got.ny = m_tdata[64:49];
				got.nz = m_tdata[80:65];
				if (expected_hits.size() == 0) begin
					if (mismatches < 10) $display("unexpected result %h", got);
					mismatches <= mismatches + 1;
				end else begin
					want = expected_hits.pop_front();
					if (want !== got) begin
						if (mismatches < 10)
							$display("mismatch: exp hit=%0d t=%h n=%h/%h/%h got hit=%0d t=%h n=%h/%h/%h",
								want.hit, want.hit_time, want.nx, want.ny, want.nz,
								got.hit, got.hit_time, got.nx, got.ny, got.nz);
						mismatches <= mismatches + 1;
					end
				end
			end
		end
	end
endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the ray/sphere intersection block
// Drives directed and random rays with random gaps and output stalls;
// the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG = 20000;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	logic [rsi_pkg::IN_W-1:0]  s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	logic [rsi_pkg::OUT_W-1:0] m_tdata;
	int                        fail_count, pending;
	int                        idle_cycles = 0;
	int                        rx_wait = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ray_sphere_intersect u_top (.*);
	rsi_checker u_chk (.*);

	// pack one ray request
	function automatic logic [rsi_pkg::IN_W-1:0] pack_ray(input logic [31:0] sx, sy, sz,
			dx, dy, dz, input logic [30:0] r, input logic br);
		return {br, r, dz, dy, dx, sz, sy, sx};
	endfunction

	task automatic send_ray(input logic [rsi_pkg::IN_W-1:0] w);
		int gap;
		gap = $urandom_range(0, 13);
		repeat (gap) @(posedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= w;
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 1'b0;
	endtask

	// well-formed ray aimed at the sphere, random scale
	function automatic logic [rsi_pkg::IN_W-1:0] aimed_ray();
		int          sh;
		logic [31:0] sv[3], dv[3];
		logic [30:0] r;
		sh = $urandom_range(0, 14);
		r = 31'($urandom_range(1, 32'h7FFF)) << sh;
		for (int i = 0; i < 3; i++) begin
			sv[i] = $urandom_range(0, 32'h3FFFF) << sh;
			if ($urandom_range(0, 1)) sv[i] = -sv[i];
			dv[i] = -(sv[i] >>> $urandom_range(0, 6)) + ($urandom_range(0, 255) - 128);
		end
		return pack_ray(sv[0], sv[1], sv[2], dv[0], dv[1], dv[2], r, 1'($urandom_range(0, 1)));
	endfunction

	// draw a random m_tready stall for every result taken
	always @(posedge clk) begin
		int w;
		if (m_tvalid && m_tready) begin
			w = $urandom_range(0, 13);
			m_tready <= (w == 0);
			rx_wait <= (w == 0) ? 0 : w - 1;
		end else if (!m_tready) begin
			if (rx_wait == 0) m_tready <= 1'b1;
			else rx_wait <= rx_wait - 1;
		end
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("ray_sphere_intersect verification failed");
			$finish;
		end
	end

	initial begin
		logic [31:0] mx;
		mx = 32'h7FFF_FFFF;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: hits, misses, extremes, special cases
		send_ray(pack_ray(32'hFFF6_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h0001_0000, 1'b0));
		send_ray(pack_ray(32'hFFF6_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h0001_0000, 1'b1));
		send_ray(pack_ray(0, 0, 0, 32'h0001_0000, 0, 0, 31'h0001_0000, 1'b0));
		send_ray(pack_ray(32'h0005_0000, 0, 0, 0, 0, 0, 31'h0001_0000, 1'b0));
		send_ray(pack_ray(32'h0005_0000, 0, 0, 32'h0001_0000, 0, 0, 31'h0001_0000, 1'b0));
		send_ray(pack_ray(32'h0005_0000, 32'h0001_0000, 0, 32'hFFFF_0000, 0, 0,
			31'h0001_0000, 1'b0));
		send_ray(pack_ray(32'h0005_0000, 32'h0002_0000, 0, 32'hFFFF_0000, 0, 0,
			31'h0001_0000, 1'b1));
		send_ray(pack_ray(32'h0005_0000, 0, 0, 32'hFFFF_0000, 0, 0, 31'h0001_0000, 1'b1));
		send_ray(pack_ray(32'h7FFF_0000, 0, 0, 32'hFFFF_FFFF, 0, 0, 31'h0000_1000, 1'b0));
		send_ray(pack_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, mx, mx, mx, '1, 1'b0));
		send_ray(pack_ray(mx, mx, mx, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1'b0));
		send_ray(pack_ray(mx, mx, mx, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 1'b1));
		send_ray(pack_ray(32'h0000_0002, 0, 0, 32'hFFFF_FFFF, 0, 0, 0, 1'b0));
		send_ray(pack_ray(0, 32'hFFF0_0000, 0, 0, 32'h0000_4000, 0, 31'h0008_0000, 1'b1));
		send_ray(pack_ray(0, 0, 32'h0010_0000, 0, 0, 32'hFFFF_0000, '1, 1'b0));
		send_ray(pack_ray(32'h0003_0000, 32'h0004_0000, 0, 32'hFFFD_0000, 32'hFFFC_0000, 0,
			31'h0005_0000, 1'b0));
		// let every directed result drain before the random part
		wait (pending == 0);
		@(posedge clk);
		for (int k = 0; k < 400; k++) begin
			if ($urandom_range(0, 3) != 0) send_ray(aimed_ray());
			else send_ray({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom});
			if (k == 200) wait (pending == 0);
		end
		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0) $display("ray_sphere_intersect verification clean");
		else $display("ray_sphere_intersect verification failed");
		$finish;
	end
endmodule
